// ===== rtl/brf_pkg.sv =====
// brf_pkg: shared types and constants for the byte ring FIFO.
// Used by every rtl module of the block except brf_ram; depends on nothing.
`timescale 1ns / 1ps
package brf_pkg;

   localparam int DEPTH           = 4096;
   localparam int POS_W           = $clog2(DEPTH);
   localparam int LEVEL_W         = 13;
   localparam int MAX_WRITE_BYTES = 8;
   localparam int MAX_READ_BYTES  = 64;
   localparam int COUNT_W         = 7;
   localparam int DATA_W          = 64;
   // queue pointers wrap naturally, so keep the depth a power of two
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_WRITE      = 2'd0,
      KIND_READ_BYTE  = 2'd1,
      KIND_READ_EMPTY = 2'd2,
      KIND_FLUSH      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WRITE = 2'd1,
      ST_READ  = 2'd2
   } state_type;

   // classified command handed from the front end to the back end
   typedef struct packed {
      op_type               op;
      logic [COUNT_W-1:0]   count;    // read count already clamped
      logic                 too_big;  // write count beyond the burst limit
      logic [DATA_W-1:0]    data;
   } cmd_type;

   // capacity and pointer clear from the register block
   typedef struct packed {
      logic                 clear;
      logic [LEVEL_W-1:0]   capacity;
   } cfg_type;

endpackage

// ===== rtl/brf_ram.sv =====
// brf_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/brf_front.sv =====
// brf_front: takes request beats and classifies them into commands.
// Depends on brf_pkg.
`timescale 1ns / 1ps
module brf_front (
   input  logic                          start,
   input  logic [1:0]                    req_op,
   input  logic [brf_pkg::COUNT_W-1:0]   req_byte_count,
   input  logic [brf_pkg::DATA_W-1:0]    req_write_data,
   input  logic                          q_full,
   output logic                          busy,
   output logic                          push,
   output brf_pkg::cmd_type              cmd
);
   import brf_pkg::*;

   op_type op;

   assign op   = op_type'(req_op);
   assign busy = q_full;
   // unknown op is dropped here and never reaches the back end
   assign push = start && !q_full && (op != OP_IGNORE);

   always_comb begin
      cmd.op      = op;
      cmd.data    = req_write_data;
      cmd.too_big = (req_byte_count > COUNT_W'(MAX_WRITE_BYTES));
      if ((op == OP_READ) && (req_byte_count > COUNT_W'(MAX_READ_BYTES))) begin
         cmd.count = COUNT_W'(MAX_READ_BYTES);
      end else begin
         cmd.count = req_byte_count;
      end
   end

endmodule

// ===== rtl/brf_cmd_queue.sv =====
// brf_cmd_queue: short command queue between front and back end.
// Depends on brf_pkg.
`timescale 1ns / 1ps
module brf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brf_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output brf_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              empty
);
   import brf_pkg::*;

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_cmd = q_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/brf_back.sv =====
// brf_back: executes queued commands against the byte ring, one byte a cycle.
// Depends on brf_pkg and brf_ram.
`timescale 1ns / 1ps
module brf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  brf_pkg::cfg_type              cfg,
   input  brf_pkg::cmd_type              cmd,
   input  logic                          q_empty,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_kind,
   output logic                          rsp_accepted,
   output logic [7:0]                    rsp_read_byte,
   output logic                          rsp_last,
   output logic [brf_pkg::LEVEL_W-1:0]   rsp_fill_level
);
   import brf_pkg::*;

   state_type            state_ff, state_in;
   logic [POS_W-1:0]     head_ff, head_in;
   logic [POS_W-1:0]     tail_ff, tail_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic [3:0]           wcnt_ff, wcnt_in;
   logic [COUNT_W-1:0]   left_ff, left_in;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic                 acc_ff, acc_in;
   logic                 last_ff, last_in;
   logic                 byte_sel_ff, byte_sel_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;

   logic                 ram_we;
   logic [7:0]           ram_rdata;
   logic [LEVEL_W-1:0]   free_space;
   logic [COUNT_W-1:0]   read_n;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                 input logic [LEVEL_W-1:0] cap);
      logic [LEVEL_W-1:0] p;
      p = LEVEL_W'(pos) + 1'b1;
      return (p >= cap) ? '0 : p[POS_W-1:0];
   endfunction

   brf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (data_ff[7:0]),
      .rd_addr (tail_ff),
      .rd_data (ram_rdata)
   );

   assign free_space = cfg.capacity - level_ff;
   assign read_n     = (level_ff < LEVEL_W'(cmd.count)) ? level_ff[COUNT_W-1:0] : cmd.count;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;
      data_in     = data_ff;
      wcnt_in     = wcnt_ff;
      left_in     = left_ff;
      valid_in    = 1'b0;
      kind_in     = KIND_WRITE;
      acc_in      = 1'b0;
      last_in     = 1'b1;
      byte_sel_in = 1'b0;
      lvl_in      = level_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               case (cmd.op)
                  OP_WRITE: begin
                     if (cmd.count == '0) begin
                        valid_in = 1'b1;
                        acc_in   = 1'b1;
                     end else if (cmd.too_big || (LEVEL_W'(cmd.count) > free_space)) begin
                        valid_in = 1'b1;
                     end else begin
                        data_in  = cmd.data;
                        wcnt_in  = cmd.count[3:0];
                        left_in  = cmd.count;
                        state_in = ST_WRITE;
                     end
                  end
                  OP_READ: begin
                     if (read_n == '0) begin
                        valid_in = 1'b1;
                        kind_in  = KIND_READ_EMPTY;
                     end else begin
                        left_in  = read_n;
                        state_in = ST_READ;
                     end
                  end
                  OP_FLUSH: begin
                     tail_in  = head_ff;
                     level_in = '0;
                     valid_in = 1'b1;
                     kind_in  = KIND_FLUSH;
                     lvl_in   = '0;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            ram_we  = 1'b1;
            data_in = data_ff >> 8;
            head_in = next_pos(head_ff, cfg.capacity);
            left_in = left_ff - 1'b1;
            if (left_ff == COUNT_W'(1)) begin
               level_in = level_ff + LEVEL_W'(wcnt_ff);
               valid_in = 1'b1;
               acc_in   = 1'b1;
               lvl_in   = level_in;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            tail_in     = next_pos(tail_ff, cfg.capacity);
            level_in    = level_ff - 1'b1;
            left_in     = left_ff - 1'b1;
            valid_in    = 1'b1;
            kind_in     = KIND_READ_BYTE;
            byte_sel_in = 1'b1;
            lvl_in      = level_in;
            last_in     = (left_ff == COUNT_W'(1));
            if (left_ff == COUNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // capacity writes must only arrive while idle; the block itself does not enforce it
      if (cfg.clear) begin
         head_in  = '0;
         tail_in  = '0;
         level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
      data_ff     <= data_in;
      wcnt_ff     <= wcnt_in;
      left_ff     <= left_in;
      kind_ff     <= kind_in;
      acc_ff      <= acc_in;
      last_ff     <= last_in;
      byte_sel_ff <= byte_sel_in;
      lvl_ff      <= lvl_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_last       = last_ff;
   assign rsp_fill_level = lvl_ff;
   // RAM read data lines up with the result beat; both are registered from the same read state
   assign rsp_read_byte  = byte_sel_ff ? ram_rdata : 8'd0;

endmodule

// ===== rtl/byte_ring_fifo_burst_top.sv =====
// Results: a flush, zero-byte or rejected write, or empty read answers with a single beat
// once the back end pops it from the queue; an accepted write answers as its last byte is
// written; a read gives one byte beat a cycle. Throughput: one byte per cycle in the back
// end while a command runs, with an idle state between commands; a 2-deep command queue sets busy.
// Reset (synchronous): ring empty, pointers zero, capacity 4096; results cannot be stalled.
// byte_ring_fifo_burst_top: top level; depends on brf_pkg, brf_front, brf_cmd_queue, brf_back.
`timescale 1ns / 1ps
module byte_ring_fifo_burst_top (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [brf_pkg::COUNT_W-1:0]   req_byte_count,
   input  logic [brf_pkg::DATA_W-1:0]    req_write_data,
   // result channel, one beat per strobe
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_kind,
   output logic                          rsp_accepted,
   output logic [7:0]                    rsp_read_byte,
   output logic                          rsp_last,
   output logic [brf_pkg::LEVEL_W-1:0]   rsp_fill_level,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import brf_pkg::*;

   logic [LEVEL_W-1:0] cap_ff, cap_in;
   logic               clear_ff, clear_in;
   logic               cap_wr;
   logic [LEVEL_W-1:0] wr_val;

   cmd_type            front_cmd, head_cmd;
   cfg_type            cfg;
   logic               push, pop, q_full, q_empty;

   // ---------------------------------------------------------------
   // Register block: ring_capacity at byte address 0. The low 13 bits of
   // the written value are clamped to 1..DEPTH; any write to it also clears the ring.
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign cap_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign wr_val = pwdata[LEVEL_W-1:0];

   always_comb begin
      cap_in   = cap_ff;
      clear_in = cap_wr;
      if (cap_wr) begin
         if (wr_val == '0) begin
            cap_in = LEVEL_W'(1);
         end else if (wr_val > LEVEL_W'(DEPTH)) begin
            cap_in = LEVEL_W'(DEPTH);
         end else begin
            cap_in = wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= LEVEL_W'(DEPTH);
         clear_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         clear_ff <= clear_in;
      end
   end

   assign prdata = (paddr[2] == 1'b0) ? {{(32-LEVEL_W){1'b0}}, cap_ff} : 32'd0;

   // The clear is registered alongside the new capacity, so the pointer reset and the new
   // capacity land together. Writes must come only while idle; the block does not enforce it.
   assign cfg.clear    = clear_ff;
   assign cfg.capacity = cap_ff;

   // ---------------------------------------------------------------
   // Front end: accepts command beats and classifies them.
   // ---------------------------------------------------------------
   brf_front u_front (
      .start          (start),
      .req_op         (req_op),
      .req_byte_count (req_byte_count),
      .req_write_data (req_write_data),
      .q_full         (q_full),
      .busy           (busy),
      .push           (push),
      .cmd            (front_cmd)
   );

   // ---------------------------------------------------------------
   // Command queue: decouples acceptance from byte movement.
   // ---------------------------------------------------------------
   brf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // ---------------------------------------------------------------
   // Back end: ring pointers, fill level and the byte RAM.
   // ---------------------------------------------------------------
   brf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (head_cmd),
      .q_empty        (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_accepted   (rsp_accepted),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

// ===== tb/byte_ring_fifo_burst_top_test.sv =====
// byte_ring_fifo_burst_top_test: self-checking bench for the byte ring FIFO top level.
// Depends on brf_pkg and byte_ring_fifo_burst_top; a local ring predictor checks every beat.
`timescale 1ns / 1ps
module byte_ring_fifo_burst_top_test;
   import brf_pkg::*;

   localparam logic [2:0] CAP_ADDR      = 3'd0;   // ring_capacity, register 0
   localparam int         SETTLE_CYCLES = 24;     // quiet margin before a register write
   localparam int         FULL_CAP      = 256;    // ring size for the fill and wrap test
   localparam int         TIMEOUT_NS    = 4_000_000;

   // one result beat as the block should present it
   typedef struct packed {
      kind_type             kind;
      logic                 accepted;
      logic [7:0]           read_byte;
      logic                 last;
      logic [LEVEL_W-1:0]   fill_level;
   } beat_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_op;
   logic [COUNT_W-1:0]   req_byte_count;
   logic [DATA_W-1:0]    req_write_data;
   logic                 rsp_valid;
   logic [1:0]           rsp_kind;
   logic                 rsp_accepted;
   logic [7:0]           rsp_read_byte;
   logic                 rsp_last;
   logic [LEVEL_W-1:0]   rsp_fill_level;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   byte_ring_fifo_burst_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_byte_count (req_byte_count),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_accepted   (rsp_accepted),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last),
      .rsp_fill_level (rsp_fill_level),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Ring predictor: own copy of the store, positions, level and capacity.
   // ---------------------------------------------------------------------------
   logic [7:0]    ring_store [DEPTH];
   int unsigned   ring_head;
   int unsigned   ring_tail;
   int unsigned   ring_level;
   int unsigned   ring_cap;

   beat_type      pending_beats [$];   // beats owed by the block, oldest first
   int unsigned   error_count;
   int unsigned   burst_left;          // commands left in the current sender burst

   function automatic int unsigned next_pos(input int unsigned pos);
      return (pos + 1 >= ring_cap) ? 0 : pos + 1;
   endfunction

   function automatic beat_type make_beat(input kind_type kind, input logic acc,
                                          input logic [7:0] data, input logic last);
      beat_type b;
      b.kind       = kind;
      b.accepted   = acc;
      b.read_byte  = data;
      b.last       = last;
      b.fill_level = ring_level[LEVEL_W-1:0];
      return b;
   endfunction

   // Capacity write: low 13 bits clamped to 1..DEPTH, ring emptied and positions cleared.
   function automatic void apply_capacity(input logic [31:0] value);
      int unsigned v;
      v = value & 32'h1FFF;
      if (v == 0)
         v = 1;
      if (v > DEPTH)
         v = DEPTH;
      ring_cap   = v;
      ring_head  = 0;
      ring_tail  = 0;
      ring_level = 0;
   endfunction

   // Works out the beats one accepted command causes and queues them.
   function automatic void predict_command(input op_type op, input int unsigned count,
                                           input logic [DATA_W-1:0] data);
      int unsigned n;
      logic        ok;
      case (op)
         OP_WRITE: begin
            ok = 1'b1;
            if (count != 0) begin
               if (count > MAX_WRITE_BYTES || count > ring_cap - ring_level) begin
                  ok = 1'b0;
               end else begin
                  for (int i = 0; i < count; i++) begin
                     ring_store[ring_head] = data[8*i +: 8];
                     ring_head = next_pos(ring_head);
                  end
                  ring_level += count;
               end
            end
            pending_beats.push_back(make_beat(KIND_WRITE, ok, 8'h00, 1'b1));
         end
         OP_READ: begin
            n = (count > MAX_READ_BYTES) ? MAX_READ_BYTES : count;
            if (n > ring_level)
               n = ring_level;
            if (n == 0) begin
               pending_beats.push_back(make_beat(KIND_READ_EMPTY, 1'b0, 8'h00, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  logic [7:0] b;
                  b = ring_store[ring_tail];
                  ring_tail = next_pos(ring_tail);
                  ring_level--;
                  pending_beats.push_back(make_beat(KIND_READ_BYTE, 1'b0, b, i + 1 == n));
               end
            end
         end
         OP_FLUSH: begin
            ring_tail  = ring_head;
            ring_level = 0;
            pending_beats.push_back(make_beat(KIND_FLUSH, 1'b0, 8'h00, 1'b1));
         end
         default: ;   // unknown op: silently dropped, no beat
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker: every strobed beat against the oldest owed beat.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected beat kind=%0d byte=%02h last=%0b level=%0d",
                        $realtime, rsp_kind, rsp_read_byte, rsp_last, rsp_fill_level);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_kind !== want.kind || rsp_accepted !== want.accepted ||
                rsp_read_byte !== want.read_byte || rsp_last !== want.last ||
                rsp_fill_level !== want.fill_level) begin
               error_count++;
               if (error_count <= 10)
                  $display({"%0t: beat mismatch exp kind=%0d acc=%0b byte=%02h last=%0b",
                            " lvl=%0d, got kind=%0d acc=%0b byte=%02h last=%0b lvl=%0d"},
                           $realtime, want.kind, want.accepted, want.read_byte, want.last,
                           want.fill_level, rsp_kind, rsp_accepted, rsp_read_byte,
                           rsp_last, rsp_fill_level);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Command sender. Works in bursts; between most bursts start drops for a random
   // gap. A command is taken at the edge that sees start high and busy low.
   // ---------------------------------------------------------------------------
   task automatic send_cmd(input op_type op, input int unsigned count,
                           input logic [DATA_W-1:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         // a quarter of bursts follow on with no gap; some bursts run long
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start          <= 1'b1;
      req_op         <= op;
      req_byte_count <= count[COUNT_W-1:0];
      req_write_data <= data;
      do @(posedge clock); while (busy);
      predict_command(op, count, data);
   endtask

   // Holds off the sender until every owed beat has arrived and the block is quiet.
   task automatic drain_results();
      start      <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_beats.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write while idle: setup beat, then access beat (pready always high).
   task automatic write_capacity(input logic [31:0] value);
      drain_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAP_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_capacity(value);
   endtask

   function automatic logic [DATA_W-1:0] rand_data();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Default capacity: every op, count extremes, empty reads, op 3 dropped.
   task automatic test_basic_ops();
      send_cmd(OP_WRITE, 0, '1);                           // zero-byte write, no effect
      send_cmd(OP_READ, 4, '0);                            // empty ring -> empty beat
      send_cmd(OP_WRITE, 8, '1);
      send_cmd(OP_WRITE, 8, 64'h0123_4567_89ab_cdef);
      send_cmd(OP_WRITE, MAX_WRITE_BYTES + 1, rand_data()); // oversized, rejected
      send_cmd(OP_WRITE, 127, rand_data());                // count all ones, rejected
      send_cmd(OP_READ, 0, '0);                            // zero count, empty beat
      send_cmd(OP_IGNORE, 5, rand_data());                 // dropped, no beat
      send_cmd(OP_READ, 127, '0);                          // cut to 64, gets the 16 held
      send_cmd(OP_WRITE, 3, 64'h0000_0000_00a5_5aff);
      send_cmd(OP_FLUSH, 0, '0);
      send_cmd(OP_READ, 5, '0);                            // nothing left after flush
      send_cmd(OP_WRITE, 5, 64'h5555_5555_5555_5555);
      send_cmd(OP_READ, MAX_READ_BYTES, '0);
   endtask

   // Capacity 0 taken as 1, then a one-byte ring wrapping on every beat.
   task automatic test_tiny_ring();
      write_capacity(32'd0);
      send_cmd(OP_WRITE, 2, rand_data());                  // more than the ring holds
      send_cmd(OP_WRITE, 1, 64'h0000_0000_0000_003c);
      send_cmd(OP_WRITE, 1, rand_data());                  // full, rejected
      send_cmd(OP_READ, 4, '0);
      write_capacity(32'd1);
      repeat (4) begin
         send_cmd(OP_WRITE, 1, rand_data());
         send_cmd(OP_READ, 1, '0);
      end
   endtask

   // Fill a whole ring, refuse one more byte, wrap the head, then flush.
   task automatic test_full_ring();
      write_capacity(FULL_CAP);
      repeat (FULL_CAP / 8) send_cmd(OP_WRITE, 8, rand_data());
      send_cmd(OP_WRITE, 1, rand_data());                  // no room left
      send_cmd(OP_WRITE, 0, rand_data());
      send_cmd(OP_READ, 127, '0);
      send_cmd(OP_WRITE, 8, rand_data());                  // head, wrapped by the fill, writes from the bottom again
      send_cmd(OP_READ, 64, '0);
      drain_results();                                     // sender pause, all beats home
      send_cmd(OP_FLUSH, 0, '0);
      send_cmd(OP_READ, 1, '0);
   endtask

   // Random traffic at one capacity; write_pct steers the level up or down.
   task automatic test_random_phase(input logic [31:0] cap, input int unsigned write_pct,
                                    input int unsigned items);
      int unsigned done_items;
      int unsigned pick;
      int unsigned count;
      write_capacity(cap);
      done_items = 0;
      while (done_items < items) begin
         pick = $urandom_range(0, 99);
         if (pick < write_pct) begin
            pick  = $urandom_range(0, 99);
            count = (pick < 85) ? $urandom_range(1, MAX_WRITE_BYTES) :
                    (pick < 90) ? 0 : $urandom_range(MAX_WRITE_BYTES + 1, 127);
            send_cmd(OP_WRITE, count, rand_data());
            done_items++;
         end else if (pick < 92) begin
            pick  = $urandom_range(0, 99);
            count = (pick < 70) ? $urandom_range(1, 8) :
                    (pick < 90) ? $urandom_range(9, MAX_READ_BYTES) :
                    (pick < 95) ? 0 : $urandom_range(MAX_READ_BYTES + 1, 127);
            send_cmd(OP_READ, count, rand_data());
            done_items++;
         end else if (pick < 97) begin
            send_cmd(OP_FLUSH, $urandom_range(0, 127), rand_data());
            done_items++;
         end else begin
            send_cmd(OP_IGNORE, $urandom_range(0, 127), rand_data());
         end
         if ($urandom_range(0, 199) == 0)
            drain_results();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_op         <= OP_WRITE;
      req_byte_count <= '0;
      req_write_data <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= CAP_ADDR;
      pwdata         <= '0;
      error_count    = 0;
      burst_left     = 0;
      apply_capacity(32'd4096);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_tiny_ring();
      test_full_ring();
      test_random_phase(32'd2, 60, 50);
      test_random_phase(32'd9, 65, 80);
      test_random_phase(32'd37, 40, 80);
      test_random_phase($urandom_range(1, DEPTH), 55, 70);
      test_random_phase(32'h1FFF, 70, 80);                 // above DEPTH, clamped
      test_random_phase(32'd300, 45, 60);

      drain_results();
      error_count += pending_beats.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hard stop if beats never arrive or the block locks up
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_front.sv
rtl/brf_cmd_queue.sv
rtl/brf_back.sv
rtl/byte_ring_fifo_burst_top.sv
tb/byte_ring_fifo_burst_top_test.sv
